// ===== rtl/psvm_pkg.sv =====
// ----------------------------------------------------------------------------
// psvm_pkg: shared types and constants of the sample voice mixer
// Word layouts, action codes, controller states and controller commands.
// ----------------------------------------------------------------------------
package psvm_pkg;

	localparam int NUM_VOICES   = 16;
	localparam int NUM_DRUMS    = 8;
	localparam int SAMPLE_DEPTH = 4096;   // power of two: drum and pointer concatenate

	// fixed field widths
	localparam int ACTION_W    = 2;
	localparam int DRUM_W      = 3;
	localparam int ADDR_W      = 12;
	localparam int SAMPLE_W    = 16;
	localparam int LEN_W       = 13;
	localparam int MASK_W      = 8;
	localparam int COUNT_OUT_W = 5;

	// derived widths
	localparam int VOICE_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int PTR_W    = $clog2(SAMPLE_DEPTH);
	localparam int MEM_AW   = DRUM_W + PTR_W;
	localparam int VCOUNT_W = $clog2(NUM_VOICES + 1);
	localparam int SUM_W    = SAMPLE_W + VCOUNT_W;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD_SAMPLE = 2'd0,
		ACT_LOAD_LENGTH = 2'd1,
		ACT_FRAME       = 2'd2
	} action_t;

	typedef struct packed {
		logic [ACTION_W-1:0]        action;
		logic [DRUM_W-1:0]          drum;
		logic [ADDR_W-1:0]          address;
		logic signed [SAMPLE_W-1:0] value;
		logic [LEN_W-1:0]           length;
		logic [MASK_W-1:0]          trigger_mask;
		logic                       play_backwards;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix_sample;
		logic [COUNT_OUT_W-1:0]     active_voices;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_STEP,
		ST_DRAIN,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic               load_sample;
		logic               load_length;
		logic               frame_begin;
		logic               start_en;
		logic [DRUM_W-1:0]  start_drum;
		logic               step_en;
		logic [VOICE_W-1:0] step_voice;
		logic               out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/psvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// psvm_ctrl: frame sequencer
// Decodes accepted words, walks drums for voice starts, then voices for mixing.
// ----------------------------------------------------------------------------
module psvm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic [1:0]           action,
	output logic                 item_stall,
	output psvm_pkg::dp_cmd_t    cmd,
	input  psvm_pkg::dp_status_t sts
);
	import psvm_pkg::*;

	ctl_state_t         state_q, state_d;
	logic [DRUM_W-1:0]  drum_cnt_q;
	logic [VOICE_W-1:0] voice_cnt_q;
	logic               last_drum, last_voice;

	assign last_drum  = (drum_cnt_q == DRUM_W'(NUM_DRUMS - 1));
	assign last_voice = (voice_cnt_q == VOICE_W'(NUM_VOICES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drum_cnt_q  <= '0;
			voice_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_START) begin
				drum_cnt_q <= last_drum ? '0 : drum_cnt_q + DRUM_W'(1);
			end
			if (state_q == ST_STEP) begin
				voice_cnt_q <= last_voice ? '0 : voice_cnt_q + VOICE_W'(1);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					unique case (action)
						ACT_LOAD_SAMPLE: cmd.load_sample = 1'b1;
						ACT_LOAD_LENGTH: cmd.load_length = 1'b1;
						ACT_FRAME: begin
							cmd.frame_begin = 1'b1;
							state_d         = ST_START;
						end
						default: ;   // unused code, word dropped
					endcase
				end
			end
			ST_START: begin
				cmd.start_en   = 1'b1;
				cmd.start_drum = drum_cnt_q;
				if (last_drum) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step_en    = 1'b1;
				cmd.step_voice = voice_cnt_q;
				if (last_voice) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;   // last read word lands in the sum
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_frame_starts_at_drum0: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.frame_begin |=> (state_q == ST_START) && (drum_cnt_q == '0))
		else $error("frame did not begin at drum 0");

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a waiting word");

	a_load_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_IDLE) && (voice_cnt_q == '0))
		else $error("sequencer not idle after result");

	a_step_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) && last_voice |=> state_q == ST_DRAIN)
		else $error("voice walk did not end in drain");

endmodule

// ===== rtl/psvm_datapath.sv =====
// ----------------------------------------------------------------------------
// psvm_datapath: sample memory, voice table, mixer and result register
// Executes one start or one voice step per cycle as commanded.
// ----------------------------------------------------------------------------
module psvm_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psvm_pkg::in_word_t    item,
	input  psvm_pkg::dp_cmd_t     cmd,
	input  logic                  result_stall,
	output logic                  result_valid,
	output psvm_pkg::out_word_t   result,
	output psvm_pkg::dp_status_t  sts
);
	import psvm_pkg::*;

	localparam int SMAX = 2 ** (SAMPLE_W - 1) - 1;
	localparam int CMAX = 2 ** COUNT_OUT_W - 1;

	logic signed [SAMPLE_W-1:0] mem [2 ** MEM_AW];
	logic [LEN_W-1:0]           len_q [NUM_DRUMS];
	logic [NUM_VOICES-1:0]      busy_q;
	logic [DRUM_W-1:0]          vdrum_q [NUM_VOICES];
	logic [PTR_W-1:0]           vptr_q [NUM_VOICES];
	logic [MASK_W-1:0]          mask_q;
	logic                       back_q;
	logic signed [SAMPLE_W-1:0] rdata_s1;
	logic                       rd_vld_s1;
	logic signed [SUM_W-1:0]    acc_q;
	logic [VCOUNT_W-1:0]        count_q;

	logic                       drum_ok, addr_ok;
	logic [LEN_W-1:0]           len_sat;
	logic [DRUM_W-1:0]          len_idx;
	logic [LEN_W-1:0]           len_rd;
	logic                       free_found;
	logic [VOICE_W-1:0]         free_idx;
	logic                       do_start;
	logic [PTR_W-1:0]           start_ptr;
	logic [DRUM_W-1:0]          cur_drum;
	logic [PTR_W-1:0]           cur_ptr;
	logic                       cur_busy, do_step;
	logic [LEN_W-1:0]           fwd_next;
	logic [PTR_W-1:0]           next_ptr;
	logic                       still;
	logic signed [SUM_W-1:0]    scaled;
	logic signed [SAMPLE_W-1:0] mix_sat;
	logic [COUNT_OUT_W-1:0]     count_sat;

	// load decode
	assign drum_ok = (int'(item.drum) < NUM_DRUMS);
	assign addr_ok = (int'(item.address) < SAMPLE_DEPTH);
	assign len_sat = (int'(item.length) > SAMPLE_DEPTH) ? LEN_W'(SAMPLE_DEPTH) : item.length;

	// voice entry under step
	assign cur_drum = vdrum_q[cmd.step_voice];
	assign cur_ptr  = vptr_q[cmd.step_voice];
	assign cur_busy = busy_q[cmd.step_voice];
	assign do_step  = cmd.step_en && cur_busy;

	// one length read per cycle: start drum or stepped voice's drum
	assign len_idx = cmd.start_en ? cmd.start_drum : cur_drum;
	assign len_rd  = len_q[len_idx];

	// lowest free voice
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int v = NUM_VOICES - 1; v >= 0; v--) begin
			if (!busy_q[v]) begin
				free_found = 1'b1;
				free_idx   = VOICE_W'(v);
			end
		end
	end

	assign do_start  = cmd.start_en && mask_q[cmd.start_drum] && (len_rd != '0) && free_found;
	assign start_ptr = back_q ? PTR_W'(len_rd - LEN_W'(1)) : '0;

	// pointer step; backward stops on reaching word 0
	always_comb begin
		fwd_next = LEN_W'(cur_ptr) + LEN_W'(1);
		if (back_q) begin
			next_ptr = (cur_ptr == '0) ? '0 : cur_ptr - PTR_W'(1);
			still    = (cur_ptr > PTR_W'(1));
		end else begin
			next_ptr = PTR_W'(fwd_next);
			still    = (fwd_next < len_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample && drum_ok && addr_ok) begin
			mem[{item.drum, PTR_W'(item.address)}] <= item.value;
		end
		rdata_s1 <= mem[{cur_drum, cur_ptr}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			rd_vld_s1 <= 1'b0;
			for (int d = 0; d < NUM_DRUMS; d++) begin
				len_q[d] <= '0;
			end
		end else begin
			rd_vld_s1 <= do_step;
			if (cmd.load_length && drum_ok) begin
				len_q[item.drum] <= len_sat;
			end
			if (do_start) begin
				busy_q[free_idx] <= 1'b1;
			end
			if (do_step) begin
				busy_q[cmd.step_voice] <= still;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_begin) begin
			mask_q  <= item.trigger_mask;
			back_q  <= item.play_backwards;
			acc_q   <= '0;
			count_q <= '0;
		end
		if (do_start) begin
			vdrum_q[free_idx] <= cmd.start_drum;
			vptr_q[free_idx]  <= start_ptr;
		end
		if (do_step) begin
			vptr_q[cmd.step_voice] <= next_ptr;
			if (still) begin
				count_q <= count_q + VCOUNT_W'(1);
			end
		end
		if (rd_vld_s1) begin
			acc_q <= acc_q + SUM_W'(rdata_s1);
		end
	end

	// quarter scale, floor, then clamp to Q1.15
	always_comb begin
		scaled = acc_q >>> 2;
		if (scaled > SUM_W'(SMAX)) begin
			mix_sat = SAMPLE_W'(SMAX);
		end else if (scaled < SUM_W'(-SMAX - 1)) begin
			mix_sat = SAMPLE_W'(-SMAX - 1);
		end else begin
			mix_sat = scaled[SAMPLE_W-1:0];
		end
		count_sat = (int'(count_q) > CMAX) ? COUNT_OUT_W'(CMAX) : COUNT_OUT_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.mix_sample    <= mix_sat;
			result.active_voices <= count_sat;
		end
	end

	assign sts.out_free = !result_valid || !result_stall;

	a_count_matches_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> int'(result.active_voices) == $countones(busy_q))
		else $error("voice count disagrees with busy bits");

	a_no_start_while_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_start |-> !do_step && !rd_vld_s1)
		else $error("voice start overlaps mixing");

endmodule

// ===== rtl/polyphonic_sample_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// polyphonic_sample_voice_mixer: 16-voice drum sample playback and mix
// Load words: complete in the accept cycle. Frame word: result register loaded at finish,
// next word taken once the sequencer is idle again (later if the result is stalled);
// the walk is set by 8 drum starts plus 16 voice reads of the single memory port.
// Reset: all voices free, drum lengths zero; sample memory keeps no reset.
// ----------------------------------------------------------------------------
module polyphonic_sample_voice_mixer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  psvm_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output psvm_pkg::out_word_t result
);
	import psvm_pkg::*;

	// Controller to datapath: one command word per cycle.
	//   idle       : accept one word; loads complete in the accept cycle
	//   drum start : drums 0..7 in order, each triggered drum of nonzero length grabs the lowest free voice
	//   voice step : voices 0..15, read word, move pointer, free at the end
	//   drain      : last memory word enters the sum
	//   finish     : quarter scale and clamp into the result register
	dp_cmd_t    cmd;
	dp_status_t sts;

	psvm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.action     (item.action),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Result register parts the output from the sequencer: loads keep
	// flowing while a mixed word waits; a new frame waits only at finish.
	psvm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.sts          (sts)
	);

endmodule

// ===== bench/tb_polyphonic_sample_voice_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphonic_sample_voice_mixer: self-checking bench of the drum voice mixer
// Sends sample loads, length loads, frame ticks and reserved words with random
// gaps. A local mirror of the voice allocator and mixer predicts every mix
// word, and each result taken under random stalls is checked against it.
// ----------------------------------------------------------------------------
module tb_polyphonic_sample_voice_mixer;
	import psvm_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_WORDS  = 400;
	localparam int MAX_LENGTH    = (1 << LEN_W) - 1;

	// action code that the block must ignore
	localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] PEAK_POS = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = 16'sh8000;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	in_word_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result;

	polyphonic_sample_voice_mixer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------
	// Mirror of the block state. Everything clears to zero / free, which
	// is the reset state; the written map keeps frames away from words
	// that were never loaded.
	// ------------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] snd_mem     [NUM_DRUMS*SAMPLE_DEPTH];
	bit                         snd_written [NUM_DRUMS*SAMPLE_DEPTH];
	int                         drum_len    [NUM_DRUMS];
	bit                         voice_on    [NUM_VOICES];
	int                         voice_drm   [NUM_VOICES];
	int                         voice_pos   [NUM_VOICES];

	out_word_t mix_expected[$];     // mix words still owed by the block
	int        mismatches  = 0;
	int        cycle_count = 0;
	int        words_sent  = 0;     // every word taken by the block
	bit        no_idle     = 1'b0;  // both sides run flat out while set

	task automatic log_mismatch(input string msg);
		$display("mismatch @%0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// Each triggered drum, lowest index first, grabs the lowest free voice.
	// A drum of length zero takes nothing; with all voices busy it is lost.
	function automatic void start_voices(logic [MASK_W-1:0] mask, logic back);
		bit placed;
		for (int d = 0; d < NUM_DRUMS && d < MASK_W; d++) begin
			placed = 1'b0;
			if (mask[d] && drum_len[d] != 0) begin
				for (int v = 0; v < NUM_VOICES; v++) begin
					if (!placed && !voice_on[v]) begin
						placed       = 1'b1;
						voice_on[v]  = 1'b1;
						voice_drm[v] = d;
						// reverse start uses the length of the drum itself
						voice_pos[v] = back ? drum_len[d] - 1 : 0;
					end
				end
			end
		end
	endfunction

	// Memory index of the first word that this frame would read before it
	// was ever loaded, or -1. Voice state is restored afterwards.
	function automatic int first_unwritten_read(logic [MASK_W-1:0] mask, logic back);
		bit on_save  [NUM_VOICES];
		int drm_save [NUM_VOICES];
		int pos_save [NUM_VOICES];
		int miss;
		int a;
		on_save  = voice_on;
		drm_save = voice_drm;
		pos_save = voice_pos;
		miss     = -1;
		start_voices(mask, back);
		for (int v = 0; v < NUM_VOICES; v++) begin
			a = voice_drm[v] * SAMPLE_DEPTH + voice_pos[v];
			if (miss < 0 && voice_on[v] && !snd_written[a])
				miss = a;
		end
		voice_on  = on_save;
		voice_drm = drm_save;
		voice_pos = pos_save;
		return miss;
	endfunction

	// Applies one accepted word to the mirror; a frame tick owes a mix word.
	function automatic void predict_mix(in_word_t w);
		int        sum;
		int        q;
		int        busy_cnt;
		int        p;
		int        a;
		out_word_t r;
		case (w.action)
			ACT_LOAD_SAMPLE: begin
				if (w.drum < NUM_DRUMS && w.address < SAMPLE_DEPTH) begin
					a              = int'(w.drum) * SAMPLE_DEPTH + int'(w.address);
					snd_mem[a]     = w.value;
					snd_written[a] = 1'b1;
				end
			end
			ACT_LOAD_LENGTH: begin
				// lengths past the memory depth clip to it
				if (w.drum < NUM_DRUMS)
					drum_len[w.drum] = (w.length > SAMPLE_DEPTH) ? SAMPLE_DEPTH : int'(w.length);
			end
			ACT_FRAME: begin
				sum      = 0;
				busy_cnt = 0;
				start_voices(w.trigger_mask, w.play_backwards);
				for (int v = 0; v < NUM_VOICES; v++) begin
					if (voice_on[v]) begin
						p   = voice_pos[v];
						sum += int'(snd_mem[voice_drm[v] * SAMPLE_DEPTH + p]);
						if (!w.play_backwards) begin
							p++;
							if (p >= drum_len[voice_drm[v]])
								voice_on[v] = 1'b0;
						end else if (p == 0) begin
							// already at the first word: play it and stop, no wrap
							voice_on[v] = 1'b0;
						end else begin
							p--;
							if (p == 0)
								voice_on[v] = 1'b0;
						end
						voice_pos[v] = p;
						if (voice_on[v])
							busy_cnt++;
					end
				end
				// quarter scale rounds toward minus infinity, then clip to Q1.15
				q = sum >>> 2;
				if (q > 32767)
					q = 32767;
				if (q < -32768)
					q = -32768;
				if (busy_cnt > 31)
					busy_cnt = 31;
				r.mix_sample    = q[SAMPLE_W-1:0];
				r.active_voices = busy_cnt[COUNT_OUT_W-1:0];
				mix_expected.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stall, check every word taken.
	// ------------------------------------------------------------------
	always @(posedge clk)
		result_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 24);

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (mix_expected.size() == 0) begin
				log_mismatch($sformatf("mix word %h with nothing pending", result));
			end else begin
				want = mix_expected.pop_front();
				if (result.mix_sample !== want.mix_sample)
					log_mismatch($sformatf("mix_sample got %0d want %0d",
						result.mix_sample, want.mix_sample));
				if (result.active_voices !== want.active_voices)
					log_mismatch($sformatf("active_voices got %0d want %0d",
						result.active_voices, want.active_voices));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Item side
	// ------------------------------------------------------------------

	// random content in every field; callers overwrite the ones that matter
	function automatic in_word_t noise_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(in_word_t)-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(9))
			0:       return PEAK_POS;
			1:       return PEAK_NEG;
			default: return raw[SAMPLE_W-1:0];
		endcase
	endfunction

	// Offers one word, holds it until taken, then updates the mirror.
	// Valid is only dropped in cycles where nothing else drives it.
	task automatic drive_word(input in_word_t w);
		if (!no_idle) begin
			while ($urandom_range(99) < 24) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item       <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		predict_mix(w);
		words_sent++;
	endtask

	task automatic load_sample(input int d, input int a, input logic signed [SAMPLE_W-1:0] v);
		in_word_t w;
		w         = noise_word();
		w.action  = ACT_LOAD_SAMPLE;
		w.drum    = d[DRUM_W-1:0];
		w.address = a[ADDR_W-1:0];
		w.value   = v;
		drive_word(w);
	endtask

	task automatic load_length(input int d, input int len);
		in_word_t w;
		w        = noise_word();
		w.action = ACT_LOAD_LENGTH;
		w.drum   = d[DRUM_W-1:0];
		w.length = len[LEN_W-1:0];
		drive_word(w);
	endtask

	// Any word the frame would read for the first time is loaded just
	// before it, so no frame ever touches uninitialized sample memory.
	task automatic play_frame(input logic [MASK_W-1:0] mask, input logic back);
		int       miss;
		in_word_t w;
		miss = first_unwritten_read(mask, back);
		while (miss >= 0) begin
			load_sample(miss / SAMPLE_DEPTH, miss % SAMPLE_DEPTH, pick_sample());
			miss = first_unwritten_read(mask, back);
		end
		w                = noise_word();
		w.action         = ACT_FRAME;
		w.trigger_mask   = mask;
		w.play_backwards = back;
		drive_word(w);
	endtask

	task automatic send_reserved();
		in_word_t w;
		w        = noise_word();
		w.action = ACT_RESERVED;
		drive_word(w);
	endtask

	// hold off the sender until every pending mix word has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (mix_expected.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// All lengths are zero after reset: a full mask starts nothing and the
	// mix is silent. The reserved action must leave no trace.
	task automatic test_empty_frames();
		play_frame(8'hFF, 1'b0);
		play_frame(8'h00, 1'b1);
		send_reserved();
		wait_drained();
	endtask

	// Five overlapping voices of drum 0 at full scale clip high; after the
	// words are flipped to the negative peak the next frame clips low.
	task automatic test_mix_saturation();
		load_length(0, 5);
		for (int a = 0; a < 5; a++)
			load_sample(0, a, PEAK_POS);
		for (int f = 0; f < 5; f++)
			play_frame(8'h01, 1'b0);
		for (int a = 0; a < 5; a++)
			load_sample(0, a, PEAK_NEG);
		play_frame(8'h01, 1'b0);
		wait_drained();
	endtask

	// Two long drums fill all voices, later triggers are lost; shrinking
	// the lengths frees everything on the next forward step.
	task automatic test_voice_exhaustion();
		load_length(2, MAX_LENGTH);     // clips to the full depth
		load_length(3, SAMPLE_DEPTH);
		for (int f = 0; f < 10; f++)
			play_frame(8'h0C, 1'b0);
		load_length(2, 1);
		load_length(3, 1);
		play_frame(8'h00, 1'b0);
		wait_drained();
	endtask

	// Reverse starts: from the last word of a full-depth drum, from word 0
	// of a one-word drum (plays once, no wrap), and from word 1.
	task automatic test_reverse_play();
		load_length(3, SAMPLE_DEPTH);
		play_frame(8'h08, 1'b1);
		load_length(4, 1);
		play_frame(8'h10, 1'b1);
		load_length(5, 2);
		play_frame(8'h20, 1'b1);
		load_length(3, 2);
		play_frame(8'h00, 1'b0);        // forward step past the new length
		wait_drained();
	endtask

	// Mixed loads, frames and reserved words with mostly short drums, some long ones and
	// some zero lengths; a stretch runs with no idling on either side.
	// Sample loads that a frame needs first count toward the word budget.
	task automatic test_random_traffic();
		int                sent;
		int                base_count;
		int                pick;
		int                len;
		int                addr;
		bit                paused;
		logic [MASK_W-1:0] mask;
		base_count = words_sent;
		sent       = 0;
		paused     = 1'b0;
		while (sent < RANDOM_WORDS) begin
			no_idle <= (sent >= 150 && sent < 250);
			pick = $urandom_range(99);
			if (pick < 50) begin
				case ($urandom_range(9))
					0:       mask = '0;
					1:       mask = '1;
					default: mask = MASK_W'($urandom_range(0, 255) & $urandom_range(0, 255));
				endcase
				play_frame(mask, $urandom_range(3) == 0);
			end else if (pick < 65) begin
				case ($urandom_range(19))
					0, 1:    len = 0;
					2:       len = $urandom_range(25, 300);
					3:       len = $urandom_range(SAMPLE_DEPTH, MAX_LENGTH);
					4:       len = $urandom_range(0, MAX_LENGTH);
					default: len = $urandom_range(1, 24);
				endcase
				load_length($urandom_range(0, NUM_DRUMS - 1), len);
			end else if (pick < 95) begin
				addr = ($urandom_range(4) == 0) ? $urandom_range(0, SAMPLE_DEPTH - 1)
				                                : $urandom_range(0, 31);
				load_sample($urandom_range(0, NUM_DRUMS - 1), addr, pick_sample());
			end else begin
				send_reserved();
			end
			sent = words_sent - base_count;
			if (!paused && sent >= RANDOM_WORDS * 3 / 4) begin
				paused = 1'b1;
				wait_drained();
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_frames();
		test_mix_saturation();
		test_voice_exhaustion();
		test_reverse_play();
		test_random_traffic();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && mix_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
